[hw/rtl/tiered_lru_key_value_cache_core_assert.svh]
// Assertion macros for the tiered LRU key/value cache core.
// Expects clk and rst_n in the scope of the including module.
`ifndef TIERED_LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define TIERED_LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define TLKV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define TLKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tlkv_pkg.sv]
// Shared types, codes and helpers of the tiered LRU key/value cache.
// No dependencies.
`default_nettype none

package tlkv_pkg;

    // Request op codes
    localparam logic [2:0] OP_STORE  = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_EVICT  = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_INVAL  = 3'd4;
    localparam logic [2:0] OP_RECORD = 3'd5;
    localparam logic [2:0] OP_STATS  = 3'd6;

    // Result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_INVALID  = 2'd1;
    localparam logic [1:0] STS_NOTFOUND = 2'd2;

    // Fixed field widths
    localparam int KEY_W   = 64;
    localparam int STAMP_W = 64;
    localparam int SIZE_W  = 6;
    localparam int IDX_W   = 8;
    localparam int META_W  = KEY_W + STAMP_W + SIZE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PWR,
        ST_LRD,
        ST_LWAIT,
        ST_LOUT,
        ST_RESP
    } state_t;

    // Control into the slot scan unit
    typedef struct packed {
        logic               clr;
        logic               step;
        logic               slot_v;
        logic [IDX_W-1:0]   idx;
    } scan_ctl_t;

    // Findings of a tier scan
    typedef struct packed {
        logic               match_found;
        logic [IDX_W-1:0]   match_idx;
        logic [SIZE_W-1:0]  match_size;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic               old_found;
        logic [IDX_W-1:0]   old_idx;
        logic [SIZE_W-1:0]  old_size;
    } scan_res_t;

    // Keep byte b of word widx when widx*8+b lies below sz
    function automatic logic [63:0] byte_mask(input logic [5:0] sz, input logic [5:0] widx);
        logic [63:0] m;
        logic [8:0]  pos;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            pos = {widx, 3'b000} + 9'(b);
            if (pos < {3'b000, sz})
            begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tiered_lru_key_value_cache_core.sv]
// Tiered LRU key/value cache core.
// Store commit and evict: a scan of the tier, then a decide step; a store then writes
// every payload word of the slot, one per cycle; both end with a result.
// Lookup: a scan of the tier, then a read, a wait and an output state per returned word.
// Other requests go straight to the result. One request at a time; the meta RAM read port sets the scan length.
// Reset clears valid bits, counters and the sequencer; clock and generation start at one.
`default_nettype none

module tiered_lru_key_value_cache_core #(
    parameter int ENTRIES_PER_TIER = 16,
    parameter int PAYLOAD_BYTES    = 32,
    parameter int TIER_COUNT       = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [2:0]    op,
    input  wire logic [2:0]    tier,
    input  wire logic [63:0]   key,
    input  wire logic [63:0]   data_word,
    input  wire logic          last_word,
    input  wire logic [5:0]    payload_size,
    input  wire logic [5:0]    max_read,
    input  wire logic          was_hit,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         status,
    output logic [5:0]         stored_size,
    output logic [63:0]        read_word,
    output logic               last_result,
    output logic [4:0]         entries,
    output logic [9:0]         bytes_held,
    output logic [31:0]        hit_total,
    output logic [31:0]        miss_total,
    output logic [31:0]        evict_total,
    output logic [31:0]        generation
);
    localparam int E     = ENTRIES_PER_TIER;
    localparam int SLOTS = TIER_COUNT * E;
    localparam int W     = (PAYLOAD_BYTES + 7) / 8;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAW   = (SLOTS * W > 1) ? $clog2(SLOTS * W) : 1;
    localparam int CW    = $clog2(E + 1);
    localparam int EW    = (E > 1) ? $clog2(E) : 1;
    localparam int WCW   = $clog2(W + 1);
    localparam int WW    = (W > 1) ? $clog2(W) : 1;
    localparam int TIW   = (TIER_COUNT > 1) ? $clog2(TIER_COUNT) : 1;
    localparam int BW    = $clog2(E * PAYLOAD_BYTES + 1);

    // Sequencer and request registers
    tlkv_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WCW-1:0]   wcnt_reg, wcnt_next;
    logic [WCW-1:0]   sw_idx_reg, sw_idx_next;
    logic [WCW-1:0]   words_reg, words_next;
    logic [WCW-1:0]   nwords_reg, nwords_next;
    logic [EW-1:0]    tgt_reg, tgt_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [5:0]       lim_reg, lim_next;
    logic [5:0]       ssize_reg, ssize_next;
    logic [63:0]      rdw_reg;

    logic [2:0]       op_reg;
    logic [2:0]       tier_reg;
    logic [63:0]      key_reg;
    logic [5:0]       size_reg;
    logic [5:0]       maxr_reg;
    logic             hit_reg;
    logic [63:0]      sbuf_reg [W];

    // Cache state
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]    ent_reg [TIER_COUNT];
    logic [CW-1:0]    ent_next [TIER_COUNT];
    logic [BW-1:0]    byt_reg [TIER_COUNT];
    logic [BW-1:0]    byt_next [TIER_COUNT];
    logic [31:0]      hits_reg [TIER_COUNT];
    logic [31:0]      hits_next [TIER_COUNT];
    logic [31:0]      miss_reg [TIER_COUNT];
    logic [31:0]      miss_next [TIER_COUNT];
    logic [31:0]      evs_reg [TIER_COUNT];
    logic [31:0]      evs_next [TIER_COUNT];
    logic [63:0]      clock_reg, clock_next;
    logic [31:0]      gen_reg, gen_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       o_status_reg, o_status_next;
    logic [5:0]       o_size_reg, o_size_next;
    logic [63:0]      o_word_reg, o_word_next;
    logic             o_last_reg, o_last_next;
    logic [4:0]       o_ent_reg, o_ent_next;
    logic [9:0]       o_byt_reg, o_byt_next;
    logic [31:0]      o_hit_reg, o_hit_next;
    logic [31:0]      o_miss_reg, o_miss_next;
    logic [31:0]      o_evs_reg, o_evs_next;
    logic [31:0]      o_gen_reg, o_gen_next;

    // Datapath wires
    logic                 in_acc, out_free, lout_last;
    logic [3:0]           in_tier4, reg_tier4;
    logic                 in_tier_ok, in_tier_all, reg_tier_ok;
    logic [TIW-1:0]       tidx;
    logic [SW-1:0]        slot_base, tgt_slot, dec_slot;
    logic [CW-1:0]        cnt_m1;
    logic [EW-1:0]        dec_idx;
    logic [PAW-1:0]       pay_addr;
    tlkv_pkg::scan_ctl_t  scan_ctl;
    tlkv_pkg::scan_res_t  scan_res;
    logic                 meta_we;
    logic [tlkv_pkg::META_W-1:0] meta_wdata, meta_rdata;
    logic                 pay_we;
    logic [63:0]          pay_wdata, pay_rdata;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != tlkv_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Decode tiers
    always_comb
    begin
        in_tier4    = {1'b0, tier};
        reg_tier4   = {1'b0, tier_reg};
        in_tier_ok  = in_tier4 < 4'(TIER_COUNT);
        in_tier_all = in_tier4 == 4'(TIER_COUNT);
        reg_tier_ok = reg_tier4 < 4'(TIER_COUNT);
        tidx        = tier_reg[TIW-1:0];
    end

    // Form slot and payload addresses
    always_comb
    begin
        slot_base = SW'(int'(tidx) * E);
        cnt_m1    = cnt_reg - CW'(1);
        tgt_slot  = slot_base + SW'(tgt_reg);
        pay_addr  = PAW'(int'(tgt_slot) * W) + PAW'(wcnt_reg);
        if (scan_res.match_found)
        begin
            dec_idx = EW'(scan_res.match_idx);
        end
        else if (scan_res.free_found)
        begin
            dec_idx = EW'(scan_res.free_idx);
        end
        else
        begin
            dec_idx = EW'(scan_res.old_idx);
        end
        dec_slot  = slot_base + SW'(dec_idx);
        lout_last = (wcnt_reg + WCW'(1)) == nwords_reg;
    end

    // Drive the scan unit one slot per cycle
    always_comb
    begin
        scan_ctl.clr    = (state_reg == tlkv_pkg::ST_IDLE);
        scan_ctl.step   = (state_reg == tlkv_pkg::ST_SCAN) && (cnt_reg != '0);
        scan_ctl.slot_v = valid_reg[slot_base + SW'(cnt_m1)];
        scan_ctl.idx    = tlkv_pkg::IDX_W'(cnt_m1);
    end

    tlkv_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .cmp_key   (key_reg),
        .row_key   (meta_rdata[tlkv_pkg::META_W-1 -: tlkv_pkg::KEY_W]),
        .row_stamp (meta_rdata[tlkv_pkg::SIZE_W +: tlkv_pkg::STAMP_W]),
        .row_size  (meta_rdata[tlkv_pkg::SIZE_W-1:0]),
        .res       (scan_res)
    );

    // Key, stamp and size of every slot
    tlkv_ram #(
        .WIDTH (tlkv_pkg::META_W),
        .DEPTH (SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (dec_slot),
        .wdata (meta_wdata),
        .raddr (slot_base + SW'(cnt_reg)),
        .rdata (meta_rdata)
    );

    // Payload words of every slot
    tlkv_ram #(
        .WIDTH (64),
        .DEPTH (SLOTS * W)
    ) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_addr),
        .wdata (pay_wdata),
        .raddr (pay_addr),
        .rdata (pay_rdata)
    );

    // Sequencer and state updates
    always_comb
    begin
        logic [5:0] lim;
        logic [6:0] nfull;
        logic [5:0] wsize;
        logic [BW-1:0] sub;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        wcnt_next       = wcnt_reg;
        sw_idx_next     = sw_idx_reg;
        words_next      = words_reg;
        nwords_next     = nwords_reg;
        tgt_next        = tgt_reg;
        res_status_next = res_status_reg;
        lim_next        = lim_reg;
        ssize_next      = ssize_reg;
        valid_next      = valid_reg;
        ent_next        = ent_reg;
        byt_next        = byt_reg;
        hits_next       = hits_reg;
        miss_next       = miss_reg;
        evs_next        = evs_reg;
        clock_next      = clock_reg;
        gen_next        = gen_reg;
        out_valid_next  = out_valid_reg && out_stall;
        o_status_next   = o_status_reg;
        o_size_next     = o_size_reg;
        o_word_next     = o_word_reg;
        o_last_next     = o_last_reg;
        o_ent_next      = o_ent_reg;
        o_byt_next      = o_byt_reg;
        o_hit_next      = o_hit_reg;
        o_miss_next     = o_miss_reg;
        o_evs_next      = o_evs_reg;
        o_gen_next      = o_gen_reg;
        meta_we         = 1'b0;
        pay_we          = 1'b0;
        wsize           = scan_res.match_size;
        meta_wdata      = '0;
        pay_wdata       = '0;
        lim             = '0;
        nfull           = '0;
        sub             = '0;

        case (state_reg)
            tlkv_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                begin
                    if (op == tlkv_pkg::OP_STORE)
                    begin
                        // Buffer the word; commit on the last one
                        if (sw_idx_reg < WCW'(W))
                        begin
                            sw_idx_next = sw_idx_reg + WCW'(1);
                        end
                        if (last_word)
                        begin
                            words_next  = sw_idx_next;
                            sw_idx_next = '0;
                            if (in_tier_ok && payload_size != '0
                                && 9'(payload_size) <= 9'(PAYLOAD_BYTES))
                            begin
                                state_next = tlkv_pkg::ST_SCAN;
                            end
                            else
                            begin
                                res_status_next = tlkv_pkg::STS_INVALID;
                                state_next      = tlkv_pkg::ST_RESP;
                            end
                        end
                    end
                    else
                    begin
                        sw_idx_next = '0;
                        case (op)
                            tlkv_pkg::OP_LOOKUP, tlkv_pkg::OP_EVICT:
                            begin
                                if (in_tier_ok)
                                begin
                                    state_next = tlkv_pkg::ST_SCAN;
                                end
                                else
                                begin
                                    res_status_next = tlkv_pkg::STS_INVALID;
                                    state_next      = tlkv_pkg::ST_RESP;
                                end
                            end
                            tlkv_pkg::OP_INVAL:
                            begin
                                res_status_next = (in_tier_ok || in_tier_all) ?
                                                  tlkv_pkg::STS_OK : tlkv_pkg::STS_INVALID;
                                state_next      = tlkv_pkg::ST_RESP;
                            end
                            tlkv_pkg::OP_CLEAR, tlkv_pkg::OP_RECORD, tlkv_pkg::OP_STATS:
                            begin
                                res_status_next = in_tier_ok ?
                                                  tlkv_pkg::STS_OK : tlkv_pkg::STS_INVALID;
                                state_next      = tlkv_pkg::ST_RESP;
                            end
                            default:
                            begin
                                res_status_next = tlkv_pkg::STS_INVALID;
                                state_next      = tlkv_pkg::ST_RESP;
                            end
                        endcase
                    end
                end
            end

            tlkv_pkg::ST_SCAN:
            begin
                // Advance one slot per cycle; the last slot lands as we leave
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(E))
                begin
                    state_next = tlkv_pkg::ST_DECIDE;
                end
            end

            tlkv_pkg::ST_DECIDE:
            begin
                wcnt_next = '0;
                case (op_reg)
                    tlkv_pkg::OP_STORE:
                    begin
                        // Overwrite match, else take free slot, else evict oldest
                        if (scan_res.match_found)
                        begin
                            sub = BW'(scan_res.match_size);
                        end
                        else if (scan_res.free_found)
                        begin
                            ent_next[tidx] = ent_reg[tidx] + CW'(1);
                        end
                        else
                        begin
                            sub = BW'(scan_res.old_size);
                            evs_next[tidx] = evs_reg[tidx] + 32'd1;
                        end
                        byt_next[tidx]       = byt_reg[tidx] - sub + BW'(size_reg);
                        valid_next[dec_slot] = 1'b1;
                        meta_we    = 1'b1;
                        meta_wdata = {key_reg, clock_reg + 64'd1, size_reg};
                        clock_next = clock_reg + 64'd1;
                        tgt_next   = dec_idx;
                        state_next = tlkv_pkg::ST_PWR;
                    end
                    tlkv_pkg::OP_LOOKUP:
                    begin
                        if (!scan_res.match_found)
                        begin
                            miss_next[tidx] = miss_reg[tidx] + 32'd1;
                            res_status_next = tlkv_pkg::STS_NOTFOUND;
                            state_next      = tlkv_pkg::ST_RESP;
                        end
                        else
                        begin
                            // Refresh the stamp and work out the word count
                            hits_next[tidx] = hits_reg[tidx] + 32'd1;
                            meta_we    = 1'b1;
                            meta_wdata = {key_reg, clock_reg + 64'd1, wsize};
                            clock_next = clock_reg + 64'd1;
                            lim   = (maxr_reg < wsize) ? maxr_reg : wsize;
                            nfull = (7'(lim) + 7'd7) >> 3;
                            if (nfull == '0)
                            begin
                                nfull = 7'd1;
                            end
                            if (nfull > 7'(W))
                            begin
                                nfull = 7'(W);
                            end
                            nwords_next = WCW'(nfull);
                            lim_next    = lim;
                            ssize_next  = wsize;
                            tgt_next    = dec_idx;
                            state_next  = tlkv_pkg::ST_LRD;
                        end
                    end
                    default:
                    begin
                        // Explicit eviction of the oldest slot
                        if (scan_res.old_found)
                        begin
                            valid_next[slot_base + SW'(scan_res.old_idx)] = 1'b0;
                            byt_next[tidx] = byt_reg[tidx] - BW'(scan_res.old_size);
                            ent_next[tidx] = ent_reg[tidx] - CW'(1);
                            evs_next[tidx] = evs_reg[tidx] + 32'd1;
                        end
                        res_status_next = tlkv_pkg::STS_OK;
                        state_next      = tlkv_pkg::ST_RESP;
                    end
                endcase
            end

            tlkv_pkg::ST_PWR:
            begin
                // Write one masked payload word per cycle
                pay_we = 1'b1;
                if (wcnt_reg < words_reg)
                begin
                    pay_wdata = sbuf_reg[wcnt_reg[WW-1:0]]
                                & tlkv_pkg::byte_mask(size_reg, 6'(wcnt_reg));
                end
                wcnt_next = wcnt_reg + WCW'(1);
                if (wcnt_reg == WCW'(W - 1))
                begin
                    res_status_next = tlkv_pkg::STS_OK;
                    state_next      = tlkv_pkg::ST_RESP;
                end
            end

            tlkv_pkg::ST_LRD:
            begin
                state_next = tlkv_pkg::ST_LWAIT;
            end

            tlkv_pkg::ST_LWAIT:
            begin
                state_next = tlkv_pkg::ST_LOUT;
            end

            tlkv_pkg::ST_LOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = tlkv_pkg::STS_OK;
                    o_size_next    = ssize_reg;
                    o_word_next    = rdw_reg;
                    o_last_next    = lout_last;
                    o_ent_next     = '0;
                    o_byt_next     = '0;
                    o_hit_next     = '0;
                    o_miss_next    = '0;
                    o_evs_next     = '0;
                    o_gen_next     = '0;
                    if (lout_last)
                    begin
                        state_next = tlkv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        wcnt_next  = wcnt_reg + WCW'(1);
                        state_next = tlkv_pkg::ST_LRD;
                    end
                end
            end

            tlkv_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = res_status_reg;
                    o_size_next    = '0;
                    o_word_next    = '0;
                    o_last_next    = 1'b1;
                    o_ent_next     = '0;
                    o_byt_next     = '0;
                    o_hit_next     = '0;
                    o_miss_next    = '0;
                    o_evs_next     = '0;
                    o_gen_next     = '0;
                    if (op_reg == tlkv_pkg::OP_INVAL)
                    begin
                        gen_next = gen_reg + 32'd1;
                    end
                    if (res_status_reg == tlkv_pkg::STS_OK)
                    begin
                        case (op_reg)
                            tlkv_pkg::OP_CLEAR:
                            begin
                                for (int s = 0; s < SLOTS; s++)
                                begin
                                    if (s / ENTRIES_PER_TIER == int'(tidx))
                                    begin
                                        valid_next[s] = 1'b0;
                                    end
                                end
                                ent_next[tidx]  = '0;
                                byt_next[tidx]  = '0;
                                hits_next[tidx] = '0;
                                miss_next[tidx] = '0;
                                evs_next[tidx]  = '0;
                            end
                            tlkv_pkg::OP_INVAL:
                            begin
                                if (reg_tier_ok)
                                begin
                                    for (int s = 0; s < SLOTS; s++)
                                    begin
                                        if (s / ENTRIES_PER_TIER == int'(tidx))
                                        begin
                                            valid_next[s] = 1'b0;
                                        end
                                    end
                                    ent_next[tidx] = '0;
                                    byt_next[tidx] = '0;
                                end
                                else
                                begin
                                    valid_next = '0;
                                    for (int t = 0; t < TIER_COUNT; t++)
                                    begin
                                        ent_next[t] = '0;
                                        byt_next[t] = '0;
                                    end
                                end
                            end
                            tlkv_pkg::OP_RECORD:
                            begin
                                if (hit_reg)
                                begin
                                    hits_next[tidx] = hits_reg[tidx] + 32'd1;
                                end
                                else
                                begin
                                    miss_next[tidx] = miss_reg[tidx] + 32'd1;
                                end
                            end
                            tlkv_pkg::OP_STATS:
                            begin
                                o_ent_next  = 5'(ent_reg[tidx]);
                                o_byt_next  = 10'(byt_reg[tidx]);
                                o_hit_next  = hits_reg[tidx];
                                o_miss_next = miss_reg[tidx];
                                o_evs_next  = evs_reg[tidx];
                                o_gen_next  = gen_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    state_next = tlkv_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tlkv_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlkv_pkg::ST_IDLE;
            cnt_reg       <= '0;
            wcnt_reg      <= '0;
            sw_idx_reg    <= '0;
            valid_reg     <= '0;
            clock_reg     <= 64'd1;
            gen_reg       <= 32'd1;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < TIER_COUNT; t++)
            begin
                ent_reg[t]  <= '0;
                byt_reg[t]  <= '0;
                hits_reg[t] <= '0;
                miss_reg[t] <= '0;
                evs_reg[t]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wcnt_reg      <= wcnt_next;
            sw_idx_reg    <= sw_idx_next;
            valid_reg     <= valid_next;
            clock_reg     <= clock_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
            ent_reg       <= ent_next;
            byt_reg       <= byt_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            evs_reg       <= evs_next;
        end
    end

    // Request fields, store buffer and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= op;
            tier_reg <= tier;
            key_reg  <= key;
            size_reg <= payload_size;
            maxr_reg <= max_read;
            hit_reg  <= was_hit;
            if (op == tlkv_pkg::OP_STORE && sw_idx_reg < WCW'(W))
            begin
                sbuf_reg[sw_idx_reg[WW-1:0]] <= data_word;
            end
        end
        if (state_reg == tlkv_pkg::ST_LWAIT)
        begin
            rdw_reg <= pay_rdata & tlkv_pkg::byte_mask(lim_reg, 6'(wcnt_reg));
        end
        words_reg      <= words_next;
        nwords_reg     <= nwords_next;
        tgt_reg        <= tgt_next;
        res_status_reg <= res_status_next;
        lim_reg        <= lim_next;
        ssize_reg      <= ssize_next;
        o_status_reg   <= o_status_next;
        o_size_reg     <= o_size_next;
        o_word_reg     <= o_word_next;
        o_last_reg     <= o_last_next;
        o_ent_reg      <= o_ent_next;
        o_byt_reg      <= o_byt_next;
        o_hit_reg      <= o_hit_next;
        o_miss_reg     <= o_miss_next;
        o_evs_reg      <= o_evs_next;
        o_gen_reg      <= o_gen_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = o_status_reg;
    assign stored_size = o_size_reg;
    assign read_word   = o_word_reg;
    assign last_result = o_last_reg;
    assign entries     = o_ent_reg;
    assign bytes_held  = o_byt_reg;
    assign hit_total   = o_hit_reg;
    assign miss_total  = o_miss_reg;
    assign evict_total = o_evs_reg;
    assign generation  = o_gen_reg;

`include "tiered_lru_key_value_cache_core_assert.svh"

    `TLKV_ASSERT_NEXT(a_scan_done, state_reg == tlkv_pkg::ST_SCAN && cnt_reg == CW'(E), state_reg == tlkv_pkg::ST_DECIDE, "scan did not end after the last slot")
    `TLKV_ASSERT_NOW(a_pwr_range, state_reg == tlkv_pkg::ST_PWR, wcnt_reg < WCW'(W), "payload write index out of range")
    `TLKV_ASSERT_NEXT(a_lookup_end, state_reg == tlkv_pkg::ST_LOUT && out_free && lout_last, state_reg == tlkv_pkg::ST_IDLE && out_valid_reg && o_last_reg, "final lookup word not followed by idle")
    `TLKV_ASSERT_NOW(a_entry_bound, 1'b1, ent_reg[0] <= CW'(E), "tier entry count above capacity")

endmodule

`default_nettype wire

[hw/rtl/tlkv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tlkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [AW-1:0]            raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/tlkv_scan.sv]
// Slot scan unit: one shared key compare and stamp compare, one slot per step.
// Depends on tlkv_pkg.
`default_nettype none

module tlkv_scan (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tlkv_pkg::scan_ctl_t                ctl,
    input  wire logic [tlkv_pkg::KEY_W-1:0]         cmp_key,
    input  wire logic [tlkv_pkg::KEY_W-1:0]         row_key,
    input  wire logic [tlkv_pkg::STAMP_W-1:0]       row_stamp,
    input  wire logic [tlkv_pkg::SIZE_W-1:0]        row_size,
    output tlkv_pkg::scan_res_t                     res
);
    logic match_found_reg, free_found_reg, old_found_reg;
    logic [tlkv_pkg::IDX_W-1:0]   match_idx_reg, free_idx_reg, old_idx_reg;
    logic [tlkv_pkg::SIZE_W-1:0]  match_size_reg, old_size_reg;
    logic [tlkv_pkg::STAMP_W-1:0] old_stamp_reg;

    logic hit_now, free_now, older_now;

    // Shared compares for the slot under test
    always_comb
    begin
        hit_now   = ctl.step && ctl.slot_v && (row_key == cmp_key) && !match_found_reg;
        free_now  = ctl.step && !ctl.slot_v && !free_found_reg;
        older_now = ctl.step && ctl.slot_v && (!old_found_reg || (row_stamp < old_stamp_reg));
    end

    // Track found flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_found_reg   <= 1'b0;
        end
        else if (ctl.clr)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_found_reg   <= 1'b0;
        end
        else
        begin
            if (hit_now)
            begin
                match_found_reg <= 1'b1;
            end
            if (free_now)
            begin
                free_found_reg <= 1'b1;
            end
            if (older_now)
            begin
                old_found_reg <= 1'b1;
            end
        end
    end

    // Capture the first match, the first free slot and the oldest slot
    always_ff @(posedge clk)
    begin
        if (hit_now)
        begin
            match_idx_reg  <= ctl.idx;
            match_size_reg <= row_size;
        end
        if (free_now)
        begin
            free_idx_reg <= ctl.idx;
        end
        if (older_now)
        begin
            old_idx_reg   <= ctl.idx;
            old_size_reg  <= row_size;
            old_stamp_reg <= row_stamp;
        end
    end

    always_comb
    begin
        res.match_found = match_found_reg;
        res.match_idx   = match_idx_reg;
        res.match_size  = match_size_reg;
        res.free_found  = free_found_reg;
        res.free_idx    = free_idx_reg;
        res.old_found   = old_found_reg;
        res.old_idx     = old_idx_reg;
        res.old_size    = old_size_reg;
    end

endmodule

`default_nettype wire
